### hdl/cbc_pkg.sv
`timescale 1ns / 1ps

package cbc_pkg;

	localparam int unsigned CLOCK_REGS_DFLT = 5;
	localparam int unsigned CLK_BASE = 8;

	localparam logic [1:0] OP_ROM_READ  = 2'd0;
	localparam logic [1:0] OP_ROM_CTRL  = 2'd1;
	localparam logic [1:0] OP_RAM_READ  = 2'd2;
	localparam logic [1:0] OP_RAM_WRITE = 2'd3;

	localparam logic [2:0] MAP_NONE = 3'd0;
	localparam logic [2:0] MAP_MBC1 = 3'd1;
	localparam logic [2:0] MAP_MBC2 = 3'd2;
	localparam logic [2:0] MAP_MBC3 = 3'd3;
	localparam logic [2:0] MAP_MBC5 = 3'd4;

	localparam logic [1:0] CFG_MAPPER   = 2'd0;
	localparam logic [1:0] CFG_ROM_SIZE = 2'd1;
	localparam logic [1:0] CFG_RAM_SIZE = 2'd2;

	typedef enum logic [2:0] {
		RESP_NONE     = 3'd0,
		RESP_OPEN_BUS = 3'd1,
		RESP_ROM_FET  = 3'd2,
		RESP_RAM_FET  = 3'd3,
		RESP_RAM_STO  = 3'd4,
		RESP_INTERNAL = 3'd5
	} resp_kind_t;

endpackage

### hdl/cartridge_bank_controller.sv
`timescale 1ns / 1ps

// Cartridge bank controller: each accepted bus access gets exactly one result, presented
// on the output from a result register, and a new access can be accepted every cycle
// (one item per clock sustained) while results are taken; the input stalls only while a
// result waits at the output and the input register is full. The access is captured in an
// input register, decoded against the bank registers by shallow mask, compare and add
// logic, and the answer is held in a result register; the bank and clock registers are
// updated in that same cycle, so the next access already sees them. The configuration
// port is always ready and must only be written while no access is in flight.
module cartridge_bank_controller #(
	parameter int unsigned CLOCK_REGS = cbc_pkg::CLOCK_REGS_DFLT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  response_kind,
	output logic [22:0] mapped_address,
	output logic [7:0]  data_out,
	output logic        upper_nibble_fill
);

	import cbc_pkg::*;

	localparam int unsigned CW = (CLOCK_REGS > 1) ? $clog2(CLOCK_REGS) : 1;
	localparam int unsigned CLK_LAST = CLK_BASE + CLOCK_REGS - 1;

	logic [2:0] mapper_kind_q;
	logic [3:0] rom_size_code_q;
	logic [2:0] ram_size_code_q;

	logic       ram_enabled_q;
	logic [4:0] low_rom_bank_q;
	logic [1:0] upper_bank_bits_q;
	logic       banking_mode_q;
	logic [6:0] seven_bit_rom_bank_q;
	logic [7:0] ram_clock_select_q;
	logic [7:0] latch_previous_q;
	logic [7:0] clock_live_q [CLOCK_REGS];
	logic [7:0] clock_latched_q [CLOCK_REGS];
	logic [8:0] nine_bit_rom_bank_q;
	logic [3:0] four_bit_ram_bank_q;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;
	logic        fire_s1;

	logic        out_valid_q;
	resp_kind_t  resp_q;
	logic [22:0] maddr_q;
	logic [7:0]  dout_q;
	logic        fill_q;

	logic [3:0]  rom_shift;
	logic [8:0]  rom_mask;
	logic [23:0] rom_size;
	logic [8:0]  rom_bank;
	logic [4:0]  lo5;
	logic [3:0]  lo4;
	logic [6:0]  lo7;
	logic [15:0] rom_in_off;
	logic [23:0] rom_off;
	logic        rom_ok;

	logic [17:0] ram_size;
	logic [3:0]  nb_mask;
	logic [15:0] ram_off16;
	logic [3:0]  ram_bank;
	logic [17:0] ram_lin;
	logic        ram_ok;
	logic [22:0] ram_idx;

	logic          clk_sel;
	logic [CW-1:0] clk_idx;
	logic          wr_en_code;

	resp_kind_t  resp_d;
	logic [22:0] maddr_d;
	logic [7:0]  dout_d;
	logic        fill_d;

	assign cfg_ready = 1'b1;
	assign fire_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	assign out_valid = out_valid_q;
	assign response_kind = resp_q;
	assign mapped_address = maddr_q;
	assign data_out = dout_q;
	assign upper_nibble_fill = fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_kind_q <= MAP_NONE;
			rom_size_code_q <= '0;
			ram_size_code_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAPPER: mapper_kind_q <= cfg_data[2:0];
				CFG_ROM_SIZE: rom_size_code_q <= cfg_data;
				CFG_RAM_SIZE: ram_size_code_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= operation;
			addr_s1 <= address;
			wdata_s1 <= write_data;
		end
	end

	always_comb begin
		rom_shift = (rom_size_code_q > 4'd8) ? 4'd8 : rom_size_code_q;
		rom_mask = 9'((10'd2 << rom_shift) - 10'd1);
		rom_size = 24'h008000 << rom_shift;
		lo5 = (low_rom_bank_q == 5'd0) ? 5'd1 : low_rom_bank_q;
		lo4 = (low_rom_bank_q[3:0] == 4'd0) ? 4'd1 : low_rom_bank_q[3:0];
		lo7 = (seven_bit_rom_bank_q == 7'd0) ? 7'd1 : seven_bit_rom_bank_q;
		rom_bank = '0;
		if (mapper_kind_q == MAP_NONE || addr_s1 < 16'h4000) begin
			rom_in_off = addr_s1;
			if (mapper_kind_q == MAP_MBC1 && banking_mode_q) begin
				rom_bank = {2'b00, upper_bank_bits_q, 5'd0};
			end
		end else begin
			rom_in_off = addr_s1 - 16'h4000;
			unique case (mapper_kind_q)
				MAP_MBC1: rom_bank = {2'b00, upper_bank_bits_q, lo5};
				MAP_MBC2: rom_bank = {5'd0, lo4};
				MAP_MBC3: rom_bank = {2'b00, lo7};
				MAP_MBC5: rom_bank = nine_bit_rom_bank_q;
				default: rom_bank = '0;
			endcase
		end
		rom_off = 24'({rom_bank & rom_mask, 14'd0}) + 24'(rom_in_off);
		rom_ok = (mapper_kind_q <= MAP_MBC5) && (rom_off < rom_size);
	end

	always_comb begin
		ram_size = '0;
		nb_mask = '0;
		if (mapper_kind_q == MAP_MBC2) begin
			ram_size = 18'h00200;
		end else begin
			case (ram_size_code_q)
				3'd1: ram_size = 18'h00800;
				3'd2: ram_size = 18'h02000;
				3'd3: begin
					ram_size = 18'h08000;
					nb_mask = 4'd3;
				end
				3'd4: begin
					ram_size = 18'h20000;
					nb_mask = 4'd15;
				end
				3'd5: begin
					ram_size = 18'h10000;
					nb_mask = 4'd7;
				end
				default: ;
			endcase
		end
		ram_off16 = addr_s1 - 16'hA000;
		unique case (mapper_kind_q)
			MAP_MBC1: ram_bank = banking_mode_q ? {2'b00, upper_bank_bits_q} : 4'd0;
			MAP_MBC3: ram_bank = {2'b00, ram_clock_select_q[1:0]};
			MAP_MBC5: ram_bank = four_bit_ram_bank_q;
			default: ram_bank = '0;
		endcase
		ram_lin = 18'({ram_bank & nb_mask, 13'd0}) + 18'(ram_off16);
		if (!ram_enabled_q || ram_size == 18'd0 || mapper_kind_q > MAP_MBC5) begin
			ram_ok = 1'b0;
		end else if (mapper_kind_q == MAP_MBC2) begin
			ram_ok = 1'b1;
		end else begin
			ram_ok = ram_lin < ram_size;
		end
		ram_idx = (mapper_kind_q == MAP_MBC2) ? {14'd0, ram_off16[8:0]} : {5'd0, ram_lin};
		clk_sel = (mapper_kind_q == MAP_MBC3) && ram_enabled_q &&
			(ram_clock_select_q >= 8'(CLK_BASE)) && (ram_clock_select_q <= 8'(CLK_LAST));
		clk_idx = CW'(ram_clock_select_q - 8'(CLK_BASE));
		wr_en_code = wdata_s1[3:0] == 4'hA;
	end

	always_comb begin
		resp_d = RESP_NONE;
		maddr_d = '0;
		dout_d = '0;
		fill_d = 1'b0;
		unique case (op_s1)
			OP_ROM_READ: begin
				if (rom_ok) begin
					resp_d = RESP_ROM_FET;
					maddr_d = rom_off[22:0];
				end else begin
					resp_d = RESP_OPEN_BUS;
					dout_d = 8'hFF;
				end
			end
			OP_RAM_READ: begin
				if (clk_sel) begin
					resp_d = RESP_INTERNAL;
					dout_d = clock_latched_q[clk_idx];
				end else if (ram_ok) begin
					resp_d = RESP_RAM_FET;
					maddr_d = ram_idx;
					fill_d = mapper_kind_q == MAP_MBC2;
				end else begin
					resp_d = RESP_OPEN_BUS;
					dout_d = 8'hFF;
				end
			end
			OP_RAM_WRITE: begin
				if (!clk_sel && ram_ok) begin
					resp_d = RESP_RAM_STO;
					maddr_d = ram_idx;
					dout_d = (mapper_kind_q == MAP_MBC2) ? {4'd0, wdata_s1[3:0]} : wdata_s1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enabled_q <= 1'b0;
			low_rom_bank_q <= 5'd1;
			upper_bank_bits_q <= '0;
			banking_mode_q <= 1'b0;
			seven_bit_rom_bank_q <= 7'd1;
			ram_clock_select_q <= '0;
			latch_previous_q <= '0;
			nine_bit_rom_bank_q <= 9'd1;
			four_bit_ram_bank_q <= '0;
			for (int i = 0; i < CLOCK_REGS; i++) begin
				clock_live_q[i] <= '0;
				clock_latched_q[i] <= '0;
			end
		end else if (fire_s1) begin
			if (op_s1 == OP_RAM_WRITE && clk_sel) begin
				clock_live_q[clk_idx] <= wdata_s1;
			end
			if (op_s1 == OP_ROM_CTRL) begin
				unique case (mapper_kind_q)
					MAP_MBC1: begin
						if (addr_s1 < 16'h2000) begin
							ram_enabled_q <= wr_en_code;
						end else if (addr_s1 < 16'h4000) begin
							low_rom_bank_q <= (wdata_s1[4:0] == 5'd0) ? 5'd1 : wdata_s1[4:0];
						end else if (addr_s1 < 16'h6000) begin
							upper_bank_bits_q <= wdata_s1[1:0];
						end else if (addr_s1 < 16'h8000) begin
							banking_mode_q <= wdata_s1[0];
						end
					end
					MAP_MBC2: begin
						if (addr_s1 < 16'h4000) begin
							if (!addr_s1[8]) begin
								ram_enabled_q <= wr_en_code;
							end else begin
								low_rom_bank_q <= (wdata_s1[3:0] == 4'd0) ? 5'd1
									: {1'b0, wdata_s1[3:0]};
							end
						end
					end
					MAP_MBC3: begin
						if (addr_s1 < 16'h2000) begin
							ram_enabled_q <= wr_en_code;
						end else if (addr_s1 < 16'h4000) begin
							seven_bit_rom_bank_q <= (wdata_s1[6:0] == 7'd0) ? 7'd1
								: wdata_s1[6:0];
						end else if (addr_s1 < 16'h6000) begin
							ram_clock_select_q <= wdata_s1;
						end else if (addr_s1 < 16'h8000) begin
							if (latch_previous_q == 8'd0 && wdata_s1 == 8'd1) begin
								for (int i = 0; i < CLOCK_REGS; i++) begin
									clock_latched_q[i] <= clock_live_q[i];
								end
							end
							latch_previous_q <= wdata_s1;
						end
					end
					MAP_MBC5: begin
						if (addr_s1 < 16'h2000) begin
							ram_enabled_q <= wr_en_code;
						end else if (addr_s1 < 16'h3000) begin
							nine_bit_rom_bank_q[7:0] <= wdata_s1;
						end else if (addr_s1 < 16'h4000) begin
							nine_bit_rom_bank_q[8] <= wdata_s1[0];
						end else if (addr_s1 < 16'h6000) begin
							four_bit_ram_bank_q <= wdata_s1[3:0];
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			resp_q <= resp_d;
			maddr_q <= maddr_d;
			dout_q <= dout_d;
			fill_q <= fill_d;
		end
	end

	a_low_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		low_rom_bank_q != 5'd0)
		else $error("low ROM bank register holds zero");

	a_seven_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		seven_bit_rom_bank_q != 7'd0)
		else $error("seven-bit ROM bank register holds zero");

	a_open_bus_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && resp_q == RESP_OPEN_BUS |-> dout_q == 8'hFF && maddr_q == 23'd0)
		else $error("open bus result with wrong payload");

	a_fill_only_ram_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fill_q |-> resp_q == RESP_RAM_FET)
		else $error("nibble fill on a result that is not a RAM fetch");

	a_latch_on_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		clock_latched_q[0] != $past(clock_latched_q[0]) |->
			$past(fire_s1) && $past(op_s1) == OP_ROM_CTRL)
		else $error("latched clock changed without a control write");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(resp_q) && $stable(maddr_q))
		else $error("pending result overwritten");

endmodule
